FILE: rtl/oda_pkg.sv
`timescale 1ns / 1ps
package oda_pkg;

	localparam int TABLE_ROWS = 15;
	localparam logic [15:0] FORWARD_INDEX = 16'h2000;

	localparam logic [1:0] ACC_R  = 2'b01;
	localparam logic [1:0] ACC_W  = 2'b10;
	localparam logic [1:0] ACC_RW = 2'b11;

	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_DENIED = 3'd1;
	localparam logic [2:0] ST_LIMIT  = 3'd2;
	localparam logic [2:0] ST_NONE   = 3'd3;
	localparam logic [2:0] ST_FWD    = 3'd4;

	localparam logic REQ_READ  = 1'b0;
	localparam logic REQ_WRITE = 1'b1;

	typedef struct packed {
		logic               req_type;
		logic [15:0]        entry_index;
		logic [7:0]         entry_sub;
		logic signed [31:0] write_value;
	} req_t;

	typedef struct packed {
		logic [2:0]         status;
		logic signed [31:0] read_value;
		logic [3:0]         index_entries;
	} rsp_t;

	typedef struct packed {
		logic [15:0]        key_index;
		logic [7:0]         key_sub;
		logic [1:0]         access;
		logic               usable;
		logic signed [31:0] def;
		logic signed [31:0] lo;
		logic signed [31:0] hi;
	} od_row_t;

	localparam od_row_t OD_ROWS [TABLE_ROWS] = '{
		'{16'h4000, 8'd0, ACC_W,  1'b1, 32'sd0,      32'sd10, 32'sd1000},
		'{16'h4000, 8'd1, ACC_RW, 1'b1, 32'sd100,    32'sd0,  32'sd100},
		'{16'h4000, 8'd2, ACC_RW, 1'b1, 32'sd0,      32'sd0,  32'sd2},
		'{16'h4001, 8'd0, ACC_W,  1'b1, 32'sd0,      32'sd1,  32'sd104000},
		'{16'h4001, 8'd1, ACC_RW, 1'b1, 32'sd500,    32'sd1,  32'sd2000},
		'{16'h4001, 8'd2, ACC_RW, 1'b1, 32'sd10,     32'sd0,  32'sd2000},
		'{16'h4001, 8'd3, ACC_RW, 1'b1, 32'sd0,      32'sd0,  32'sd2},
		'{16'h4002, 8'd0, ACC_W,  1'b1, 32'sd0,      32'sd1,  32'sd104000},
		'{16'h4002, 8'd1, ACC_RW, 1'b1, 32'sd0,      32'sd0,  32'sd1000},
		'{16'h4002, 8'd2, ACC_RW, 1'b1, 32'sd500,    32'sd1,  32'sd2000},
		'{16'h4002, 8'd3, ACC_RW, 1'b1, 32'sd10,     32'sd0,  32'sd2000},
		'{16'h4003, 8'd0, ACC_W,  1'b1, 32'sd0,      32'sd0,  32'sd250880},
		'{16'h4003, 8'd1, ACC_RW, 1'b1, 32'sd128000, 32'sd0,  32'sd500000},
		'{16'h4003, 8'd2, ACC_RW, 1'b1, 32'sd32000,  32'sd0,  32'sd256000},
		'{16'hFFFF, 8'd0, ACC_R,  1'b0, 32'sd0,      32'sd0,  32'sd0}
	};

endpackage

FILE: rtl/oda_match.sv
`timescale 1ns / 1ps
module oda_match #(
	parameter int ROWS = 15
) (
	input  oda_pkg::req_t req,
	output logic [ROWS-1:0] hit_hot,
	output logic [3:0] count
);
	import oda_pkg::*;

	logic [ROWS-1:0] idx_eq;
	logic [ROWS-1:0] full_eq;

	always_comb begin
		for (int i = 0; i < ROWS; i++) begin
			idx_eq[i]  = OD_ROWS[i].usable && (OD_ROWS[i].key_index == req.entry_index);
			full_eq[i] = idx_eq[i] && (OD_ROWS[i].key_sub == req.entry_sub);
		end
	end

	// first matching row wins
	always_comb begin
		logic found;
		found = 1'b0;
		hit_hot = '0;
		for (int i = 0; i < ROWS; i++) begin
			if (full_eq[i] && !found) begin
				hit_hot[i] = 1'b1;
				found = 1'b1;
			end
		end
	end

	always_comb begin
		count = '0;
		for (int i = 0; i < ROWS; i++) begin
			count = count + 4'(idx_eq[i]);
		end
	end

endmodule

FILE: rtl/oda_store.sv
`timescale 1ns / 1ps
module oda_store #(
	parameter int ROWS = 15
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  oda_pkg::req_t req,
	input  logic [ROWS-1:0] hit_hot,
	input  logic [3:0] count,
	output oda_pkg::rsp_t rsp
);
	import oda_pkg::*;

	logic [31:0] value_q [ROWS];
	logic [1:0] acc;
	logic signed [31:0] lo;
	logic signed [31:0] hi;
	logic [31:0] cur;
	logic hit;
	logic wr;
	logic signed [31:0] wv;

	always_comb begin
		acc = '0;
		lo  = '0;
		hi  = '0;
		cur = '0;
		for (int i = 0; i < ROWS; i++) begin
			if (hit_hot[i]) begin
				acc = acc | OD_ROWS[i].access;
				lo  = lo | OD_ROWS[i].lo;
				hi  = hi | OD_ROWS[i].hi;
				cur = cur | value_q[i];
			end
		end
	end

	assign hit = |hit_hot;
	assign wv  = $signed(req.write_value);

	always_comb begin
		wr = 1'b0;
		rsp.read_value = '0;
		rsp.index_entries = count;
		if (req.entry_index == FORWARD_INDEX) begin
			rsp.status = ST_FWD;
		end else if (!hit) begin
			rsp.status = ST_NONE;
		end else if (req.req_type == REQ_READ) begin
			if (acc[0]) begin
				rsp.status = ST_OK;
				rsp.read_value = $signed(cur);
			end else begin
				rsp.status = ST_DENIED;
			end
		end else if (!acc[1]) begin
			rsp.status = ST_DENIED;
		end else if (wv < lo || wv > hi) begin
			rsp.status = ST_LIMIT;
		end else begin
			rsp.status = ST_OK;
			wr = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ROWS; i++) begin
				value_q[i] <= OD_ROWS[i].def;
			end
		end else if (en && wr) begin
			for (int i = 0; i < ROWS; i++) begin
				if (hit_hot[i]) begin
					value_q[i] <= req.write_value;
				end
			end
		end
	end

endmodule

FILE: rtl/object_dictionary_access_core.sv
`timescale 1ns / 1ps
// channel  dir  handshake              payload
// req      in   req_valid / req_stall  oda_pkg::req_t
// rsp      out  rsp_valid / rsp_stall  oda_pkg::rsp_t
//
// one beat per cycle unless stalled; accepted requests enter the request register first
// lookup, check and value update all happen between the request and response registers
// reset loads every entry with its default value and empties both registers
// a stalled response holds the request register, which then stalls req
module object_dictionary_access_core #(
	parameter int NUM_ENTRIES = 15
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  oda_pkg::req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output oda_pkg::rsp_t rsp
);
	import oda_pkg::*;

	localparam int ROWS = (NUM_ENTRIES < TABLE_ROWS) ? NUM_ENTRIES : TABLE_ROWS;

	logic valid_s1;
	req_t req_s1;
	logic rsp_valid_q;
	rsp_t rsp_q;
	logic advance;
	logic [ROWS-1:0] hit_hot;
	logic [3:0] count;
	rsp_t rsp_next;

	assign advance   = !rsp_valid_q || !rsp_stall;
	assign req_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!req_stall && req_valid) begin
			req_s1 <= req;
		end
	end

	oda_match #(.ROWS(ROWS)) u_match (
		.req     (req_s1),
		.hit_hot (hit_hot),
		.count   (count)
	);

	oda_store #(.ROWS(ROWS)) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (valid_s1 && advance),
		.req     (req_s1),
		.hit_hot (hit_hot),
		.count   (count),
		.rsp     (rsp_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import oda_pkg::*;

	localparam int NUM_ENTRIES = 15;
	localparam int RANDOM_ITEMS = 1150;

	typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

	class od_tracker;
		rsp_t expected_rsp[$];
		logic signed [31:0] stored_values [TABLE_ROWS];
		int failures;

		function new();
			foreach (stored_values[i]) stored_values[i] = OD_ROWS[i].def;
			failures = 0;
		endfunction

		function int pending();
			return expected_rsp.size();
		endfunction

		// lookup, access check, limit check and stored-value update for one accepted request
		function void note_request(req_t r);
			rsp_t want;
			int hit;
			int rows;
			logic [3:0] idx_hits;
			logic signed [31:0] v;
			logic signed [31:0] lo;
			logic signed [31:0] hi;
			want = '0;
			hit = -1;
			idx_hits = '0;
			rows = (NUM_ENTRIES < TABLE_ROWS) ? NUM_ENTRIES : TABLE_ROWS;
			for (int i = 0; i < rows; i++) begin
				if (OD_ROWS[i].usable && OD_ROWS[i].key_index == r.entry_index) begin
					idx_hits++;
					if (hit < 0 && OD_ROWS[i].key_sub == r.entry_sub)
						hit = i;
				end
			end
			want.index_entries = idx_hits;
			if (r.entry_index == FORWARD_INDEX) begin
				want.status = ST_FWD;
			end else if (hit < 0) begin
				want.status = ST_NONE;
			end else if (r.req_type == REQ_READ) begin
				if ((OD_ROWS[hit].access & ACC_R) != 0) begin
					want.status = ST_OK;
					want.read_value = stored_values[hit];
				end else begin
					want.status = ST_DENIED;
				end
			end else if ((OD_ROWS[hit].access & ACC_W) == 0) begin
				want.status = ST_DENIED;
			end else begin
				v = r.write_value;
				lo = OD_ROWS[hit].lo;
				hi = OD_ROWS[hit].hi;
				if (v < lo || v > hi) begin
					want.status = ST_LIMIT;
				end else begin
					stored_values[hit] = v;
					want.status = ST_OK;
				end
			end
			expected_rsp.push_back(want);
		endfunction

		function void check_response(rsp_t got);
			rsp_t want;
			if (expected_rsp.size() == 0) begin
				if (failures < 10)
					$display("unexpected response: status %0d value %0d entries %0d",
						got.status, got.read_value, got.index_entries);
				failures++;
				return;
			end
			want = expected_rsp.pop_front();
			if (got.status !== want.status || got.read_value !== want.read_value ||
					got.index_entries !== want.index_entries) begin
				if (failures < 10)
					$display({"mismatch: expected status %0d value %0d entries %0d, ",
						"got status %0d value %0d entries %0d"},
						want.status, want.read_value, want.index_entries,
						got.status, got.read_value, got.index_entries);
				failures++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	od_tracker sb;
	stall_mode_t stall_mode = STALL_NONE;
	int unsigned stall_left = 0;

	object_dictionary_access_core #(
		.NUM_ENTRIES(NUM_ENTRIES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// receiver back-pressure in phases of random length
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= stall_mode_t'($urandom_range(3));
			stall_left <= $urandom_range(50, 300);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			STALL_NONE: rsp_stall <= 1'b0;
			STALL_LIGHT: rsp_stall <= ($urandom_range(99) < 30);
			STALL_HEAVY: rsp_stall <= ($urandom_range(99) < 75);
			default: rsp_stall <= (stall_left % 4 == 0);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && req_valid && !req_stall)
			sb.note_request(req);
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_response(rsp);
	end

	task automatic send_req(input req_t r);
		req <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// mostly dictionary keys with values around the limits, some forwarded and stray keys
	function automatic req_t random_request();
		req_t r;
		int row;
		int unsigned pick;
		logic signed [31:0] lo;
		logic signed [31:0] hi;
		r.req_type = 1'($urandom_range(1));
		r.write_value = $urandom;
		r.entry_sub = 8'($urandom);
		pick = $urandom_range(99);
		if (pick < 80) begin
			row = $urandom_range(TABLE_ROWS - 1);
			r.entry_index = OD_ROWS[row].key_index;
			if ($urandom_range(9) != 0)
				r.entry_sub = OD_ROWS[row].key_sub;
			lo = OD_ROWS[row].lo;
			hi = OD_ROWS[row].hi;
			case ($urandom_range(9))
				0: r.write_value = lo;
				1: r.write_value = hi;
				2: r.write_value = lo - 1;
				3: r.write_value = hi + 1;
				4, 5, 6, 7: r.write_value = lo + $urandom_range(hi - lo);
				default: ;
			endcase
		end else if (pick < 88) begin
			r.entry_index = FORWARD_INDEX;
		end else begin
			r.entry_index = 16'($urandom);
		end
		return r;
	endfunction

	initial begin
		req_t directed_q[$];
		req_t r;
		int total;
		int sent;
		int burst;
		int gap;
		sb = new();
		directed_q = '{
			req_t'{REQ_READ,  16'h4000, 8'd1,   32'sd0},
			req_t'{REQ_READ,  16'h4000, 8'd0,   32'sd0},
			req_t'{REQ_WRITE, 16'h4000, 8'd0,   32'sd10},
			req_t'{REQ_WRITE, 16'h4000, 8'd0,   32'sd9},
			req_t'{REQ_WRITE, 16'h4000, 8'd0,   32'sd1001},
			req_t'{REQ_WRITE, 16'h4000, 8'd1,   32'sd100},
			req_t'{REQ_READ,  16'h4000, 8'd1,   32'sd0},
			req_t'{REQ_WRITE, 16'h4001, 8'd0,   32'sd104000},
			req_t'{REQ_WRITE, 16'h4001, 8'd0,   32'h80000000},
			req_t'{REQ_WRITE, 16'h4003, 8'd2,   32'h7FFFFFFF},
			req_t'{REQ_WRITE, 16'h4003, 8'd2,   32'hFFFFFFFF},
			req_t'{REQ_READ,  16'h2000, 8'd0,   32'sd0},
			req_t'{REQ_WRITE, 16'h2000, 8'd5,   32'sd123},
			req_t'{REQ_READ,  16'hFFFF, 8'd0,   32'sd0},
			req_t'{REQ_WRITE, 16'hFFFF, 8'd0,   32'sd0},
			req_t'{REQ_READ,  16'h0000, 8'd0,   32'sd0},
			req_t'{REQ_READ,  16'h4003, 8'hFF,  32'hFFFFFFFF},
			req_t'{REQ_WRITE, 16'h4002, 8'd2,   32'sd0},
			req_t'{REQ_READ,  16'h4002, 8'd2,   32'sd0},
			req_t'{REQ_WRITE, 16'h4003, 8'd1,   32'sd500000},
			req_t'{REQ_READ,  16'h4003, 8'd1,   32'sd0},
			req_t'{REQ_WRITE, 16'h4000, 8'd2,   32'sd3},
			req_t'{REQ_READ,  16'h4000, 8'd2,   32'sd0},
			req_t'{REQ_WRITE, 16'h4001, 8'd3,   32'sd2},
			req_t'{REQ_READ,  16'h4001, 8'd3,   32'sd0}
		};
		total = directed_q.size() + RANDOM_ITEMS;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		sent = 0;
		while (sent < total) begin
			burst = $urandom_range(1, 40);
			for (int k = 0; k < burst && sent < total; k++) begin
				r = (sent < directed_q.size()) ? directed_q[sent] : random_request();
				send_req(r);
				sent++;
				// let the pipeline empty now and then
				if (sent == directed_q.size() || sent % 300 == 0)
					drain();
			end
			gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		drain();
		repeat (10) @(posedge clk);
		if (sb.failures == 0 && sb.pending() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
